// ----- hw/rtl/nlp_pkg.sv -----
// nlp_pkg: shared types, character codes and helper functions for the
// numeric literal parser; no dependencies

package nlp_pkg;

    // default result width
    localparam int VALUE_BITS_DEFAULT = 32;

    // character codes
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_EIGHT   = 8'h38;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_UPPER_X = 8'h58;

    // digit value meaning "not a hex digit"
    localparam logic [4:0] HEX_NONE = 5'd16;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD      = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    // number base currently in effect
    typedef enum logic [1:0] {
        MODE_UNDECIDED = 2'd0,
        MODE_DEC       = 2'd1,
        MODE_OCT       = 2'd2,
        MODE_HEX       = 2'd3
    } radix_t;

    // string position: first, second, later
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_LATER  = 2'd2;

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // hex digit value, HEX_NONE when c is not a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
            return d[4:0];
        end
        if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
            d = c - CH_LOWER_A + 8'd10;
            return d[4:0];
        end
        if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            d = c - CH_UPPER_A + 8'd10;
            return d[4:0];
        end
        return HEX_NONE;
    endfunction

endpackage

// ----- hw/rtl/numeric_literal_parser.sv -----
// numeric_literal_parser: top level, character-stream integer literal parser
// depends on nlp_pkg
//
// Usage
//   s_ch carries one character per beat on a valid/ready channel; a zero
//   character ends the string. Each terminator yields exactly one beat on the
//   m_ channel (m_value, m_status); other characters yield nothing.
//   Decimal, octal (leading 0) and hex (leading 0x / 0X) are recognized;
//   overflow saturates m_value to all ones with overflow status, bad syntax
//   gives zero with bad status.
// Timing
//   One character per cycle sustained, but a terminator stalls while the
//   result register is full and m_ready is low. A character is held in the
//   input register, then the shift-add update writes the parse state and,
//   for a terminator, the result register, which drives m_valid.
//   The combinational shift-add by base 8, 10 or 16 sets the clock limit.
// Reset and stall
//   aresetn (synchronous, active low) empties both registers and clears the
//   parse state. While m_ready is low, characters keep flowing in; only a
//   terminator waits in the input register until the result register frees.
module numeric_literal_parser #(
    parameter int VALUE_BITS = nlp_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_ch,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [VALUE_BITS-1:0] m_value,
    output logic [1:0]            m_status
);

    localparam int WIDE_BITS = VALUE_BITS + 4;

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] ch_reg, ch_next;

    // parse state
    logic [1:0]            pos_reg, pos_next;
    nlp_pkg::radix_t       mode_reg, mode_next;
    logic                  bad_reg, bad_next;
    logic                  stop_reg, stop_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic                  ovf_reg, ovf_next;

    // result register
    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    nlp_pkg::status_t      status_reg, status_next;

    // datapath
    logic                  is_term;
    logic                  proc_go;
    nlp_pkg::radix_t       eff_mode;
    logic [4:0]            hex_digit;
    logic [7:0]            dec_diff;
    logic [3:0]            digit;
    logic [WIDE_BITS-1:0]  acc_wide;
    logic [WIDE_BITS-1:0]  prod;
    logic [WIDE_BITS-1:0]  sum;
    logic                  sum_ovf;
    logic                  do_acc;

    // handshake
    assign is_term = (ch_reg == nlp_pkg::CH_NUL);
    assign proc_go = in_valid_reg && (!is_term || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || proc_go;

    // input stage
    always_comb begin
        in_valid_next = in_valid_reg;
        ch_next       = ch_reg;
        if (proc_go) begin
            in_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            ch_next       = s_ch;
        end
    end

    // base in effect for this character; second char after a lone 0 is octal
    always_comb begin
        eff_mode = mode_reg;
        if (pos_reg == nlp_pkg::POS_SECOND && mode_reg == nlp_pkg::MODE_UNDECIDED) begin
            eff_mode = nlp_pkg::MODE_OCT;
        end
    end

    // digit value and shift-add candidate
    assign hex_digit = nlp_pkg::hex_val(ch_reg);
    assign dec_diff  = ch_reg - nlp_pkg::CH_ZERO;
    assign digit     = (eff_mode == nlp_pkg::MODE_HEX) ? hex_digit[3:0] : dec_diff[3:0];
    assign acc_wide  = WIDE_BITS'(acc_reg);

    always_comb begin
        case (eff_mode)
            nlp_pkg::MODE_HEX: prod = acc_wide << 4;
            nlp_pkg::MODE_DEC: prod = (acc_wide << 3) + (acc_wide << 1);
            default:           prod = acc_wide << 3;
        endcase
    end

    assign sum     = prod + WIDE_BITS'(digit);
    assign sum_ovf = |sum[WIDE_BITS-1:VALUE_BITS];

    // parse state update
    always_comb begin
        pos_next  = pos_reg;
        mode_next = mode_reg;
        bad_next  = bad_reg;
        stop_next = stop_reg;
        acc_next  = acc_reg;
        ovf_next  = ovf_reg;
        do_acc    = 1'b0;

        if (proc_go) begin
            if (is_term) begin
                pos_next  = nlp_pkg::POS_FIRST;
                mode_next = nlp_pkg::MODE_UNDECIDED;
                bad_next  = 1'b0;
                stop_next = 1'b0;
                acc_next  = '0;
                ovf_next  = 1'b0;
            end else begin
                if (!bad_reg) begin
                    if (pos_reg == nlp_pkg::POS_FIRST) begin
                        // first character picks decimal or waits on a leading 0
                        if (!nlp_pkg::is_dec(ch_reg)) begin
                            bad_next = 1'b1;
                        end else if (ch_reg != nlp_pkg::CH_ZERO) begin
                            mode_next = nlp_pkg::MODE_DEC;
                            acc_next  = VALUE_BITS'(digit);
                        end
                    end else if (pos_reg == nlp_pkg::POS_SECOND &&
                                 mode_reg == nlp_pkg::MODE_UNDECIDED &&
                                 (ch_reg == nlp_pkg::CH_LOWER_X ||
                                  ch_reg == nlp_pkg::CH_UPPER_X)) begin
                        mode_next = nlp_pkg::MODE_HEX;
                    end else begin
                        mode_next = eff_mode;
                        if (eff_mode == nlp_pkg::MODE_HEX) begin
                            if (hex_digit == nlp_pkg::HEX_NONE) begin
                                bad_next = 1'b1;
                            end else begin
                                do_acc = 1'b1;
                            end
                        end else if (!nlp_pkg::is_dec(ch_reg)) begin
                            bad_next = 1'b1;
                        end else if (eff_mode == nlp_pkg::MODE_DEC) begin
                            do_acc = 1'b1;
                        end else begin
                            // octal: an 8 or 9 freezes the value
                            if (ch_reg >= nlp_pkg::CH_EIGHT) begin
                                stop_next = 1'b1;
                            end else if (!stop_reg) begin
                                do_acc = 1'b1;
                            end
                        end
                    end
                end
                // saturating accumulate
                if (do_acc && !ovf_reg) begin
                    if (sum_ovf) begin
                        ovf_next = 1'b1;
                        acc_next = '1;
                    end else begin
                        acc_next = sum[VALUE_BITS-1:0];
                    end
                end
                if (pos_reg != nlp_pkg::POS_LATER) begin
                    pos_next = pos_reg + 2'd1;
                end
            end
        end
    end

    // result stage
    always_comb begin
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (proc_go && is_term) begin
            out_valid_next = 1'b1;
            if (bad_reg || pos_reg == nlp_pkg::POS_FIRST) begin
                value_next  = '0;
                status_next = nlp_pkg::ST_BAD;
            end else if (ovf_reg) begin
                value_next  = '1;
                status_next = nlp_pkg::ST_OVERFLOW;
            end else begin
                value_next  = acc_reg;
                status_next = nlp_pkg::ST_OK;
            end
        end
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            pos_reg       <= nlp_pkg::POS_FIRST;
            mode_reg      <= nlp_pkg::MODE_UNDECIDED;
            bad_reg       <= 1'b0;
            stop_reg      <= 1'b0;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            pos_reg       <= pos_next;
            mode_reg      <= mode_next;
            bad_reg       <= bad_next;
            stop_reg      <= stop_next;
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        ch_reg     <= ch_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    assign m_valid  = out_valid_reg;
    assign m_value  = value_reg;
    assign m_status = status_reg;

endmodule

// ----- verif/tb.sv -----
// tb: self-checking testbench for numeric_literal_parser, directed literals then random strings
// depends on nlp_pkg and numeric_literal_parser from hw/rtl; carries its own parse predictor
`timescale 1ns / 100ps

module tb;
    import nlp_pkg::*;

    localparam int VB         = 32;
    localparam int IDLE_LIMIT = 1000;
    localparam int CHAR_BUDGET = 1900;

    typedef logic [7:0] char_q_t[$];

    typedef struct packed {
        logic [VB-1:0] value;
        logic [1:0]    status;
    } lit_result_t;

    typedef struct {
        string         text;
        bit            typed;
        logic [VB-1:0] value;
        status_t       status;
    } lit_row_t;

    logic          aclk    = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    logic [7:0]    s_ch    = 8'h00;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic [VB-1:0] m_value;
    logic [1:0]    m_status;

    numeric_literal_parser #(.VALUE_BITS(VB)) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_ch     (s_ch),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_value  (m_value),
        .m_status (m_status)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // parse state of the predictor
    logic [1:0]    lit_pos;
    radix_t        lit_radix;
    bit            lit_bad;
    bit            lit_oct_stop;
    bit            lit_ovf;
    logic [VB-1:0] lit_acc;

    lit_result_t pending_results[$];
    lit_row_t    lit_rows[$];

    int  mismatch_count = 0;
    int  chars_sent     = 0;
    int  strings_sent   = 0;
    int  results_seen   = 0;
    int  ok_seen        = 0;
    int  bad_seen       = 0;
    int  ovf_seen       = 0;
    int  idle_cycles    = 0;
    bit  tx_burst       = 1'b0;
    int  rx_hold        = 0;
    int  rx_free        = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic void clear_literal();
        lit_pos      = POS_FIRST;
        lit_radix    = MODE_UNDECIDED;
        lit_bad      = 1'b0;
        lit_oct_stop = 1'b0;
        lit_ovf      = 1'b0;
        lit_acc      = '0;
    endfunction

    // digit value in base 16, 16 when the character is no hex digit
    function automatic int digit_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return 16;
    endfunction

    // shift-add one digit, saturating once the value leaves the range
    function automatic void shift_in(input int base, input int d);
        logic [63:0] wide;
        if (lit_ovf) return;
        wide = {{(64-VB){1'b0}}, lit_acc} * 64'(base) + 64'(d);
        if (wide > {{(64-VB){1'b0}}, {VB{1'b1}}}) begin
            lit_ovf = 1'b1;
            lit_acc = '1;
        end else begin
            lit_acc = wide[VB-1:0];
        end
    endfunction

    // character after the radix is known
    function automatic void take_digit(input logic [7:0] c);
        int d;
        d = digit_of(c);
        if (lit_radix == MODE_HEX) begin
            if (d > 15) lit_bad = 1'b1;
            else shift_in(16, d);
            return;
        end
        if (d > 9) begin
            lit_bad = 1'b1;
            return;
        end
        if (lit_radix == MODE_DEC) begin
            shift_in(10, d);
        end else begin
            if (d >= 8) lit_oct_stop = 1'b1;
            if (!lit_oct_stop) shift_in(8, d);
        end
    endfunction

    // one character into the predictor; returns 1 with the result on a terminator
    function automatic bit predict_char(input logic [7:0] c, output lit_result_t r);
        r = '0;
        if (c == CH_NUL) begin
            if (lit_bad || lit_pos == POS_FIRST) begin
                r.value  = '0;
                r.status = ST_BAD;
            end else if (lit_ovf) begin
                r.value  = '1;
                r.status = ST_OVERFLOW;
            end else begin
                r.value  = lit_acc;
                r.status = ST_OK;
            end
            clear_literal();
            return 1'b1;
        end
        if (!lit_bad) begin
            if (lit_pos == POS_FIRST) begin
                if (digit_of(c) > 9) begin
                    lit_bad = 1'b1;
                end else if (c != CH_ZERO) begin
                    lit_radix = MODE_DEC;
                    lit_acc   = VB'(digit_of(c));
                end
            end else if (lit_pos == POS_SECOND && lit_radix == MODE_UNDECIDED) begin
                if (c == CH_LOWER_X || c == CH_UPPER_X) begin
                    lit_radix = MODE_HEX;
                end else begin
                    lit_radix = MODE_OCT;
                    take_digit(c);
                end
            end else begin
                take_digit(c);
            end
        end
        if (lit_pos != POS_LATER) lit_pos = lit_pos + 2'd1;
        return 1'b0;
    endfunction

    // mostly short gaps, a few long ones, none in burst stretches
    function automatic int pick_gap();
        int r;
        if (tx_burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one beat on the input channel, predictor stepped at acceptance
    task automatic send_beat(input logic [7:0] c, input bit typed, input lit_result_t want);
        lit_result_t got;
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_ch    <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        chars_sent++;
        if (predict_char(c, got)) begin
            if (typed) got = want;
            pending_results.push_back(got);
        end
    endtask

    // a string of characters followed by its terminator
    task automatic send_literal(input char_q_t chars, input bit typed, input lit_result_t want);
        tx_burst = ($urandom_range(0, 4) == 0);
        foreach (chars[i]) send_beat(chars[i], 1'b0, want);
        send_beat(CH_NUL, typed, want);
        strings_sent++;
    endtask

    // hold the sender off until every result is back
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // random literal: mostly well formed, some corrupted or pure noise
    task automatic random_literal();
        string       hex_chars;
        char_q_t     chars;
        int          kind;
        int          len;
        lit_result_t none;
        hex_chars = "0123456789abcdefABCDEF";
        none = '0;
        kind = $urandom_range(0, 99);
        len  = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
        if (kind < 38) begin
            chars.push_back(8'("0") + 8'($urandom_range(1, 9)));
            repeat (len - 1) chars.push_back(8'("0") + 8'($urandom_range(0, 9)));
        end else if (kind < 63) begin
            chars.push_back(CH_ZERO);
            repeat (len) begin
                if ($urandom_range(0, 9) == 0)
                    chars.push_back(8'("0") + 8'($urandom_range(8, 9)));
                else
                    chars.push_back(8'("0") + 8'($urandom_range(0, 7)));
            end
        end else if (kind < 90) begin
            chars.push_back(CH_ZERO);
            chars.push_back($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
            repeat (len % 12) chars.push_back(hex_chars[$urandom_range(0, 21)]);
        end else if (kind < 95) begin
            // empty, lone zero or bare prefix
            case ($urandom_range(0, 2))
                0: ;
                1: chars.push_back(CH_ZERO);
                default: begin
                    chars.push_back(CH_ZERO);
                    chars.push_back(CH_LOWER_X);
                end
            endcase
        end else begin
            repeat (len) chars.push_back(8'($urandom_range(0, 255)));
        end
        // corrupt one character now and then
        if (chars.size() != 0 && $urandom_range(0, 7) == 0)
            chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(0, 255));
        send_literal(chars, 1'b0, none);
    endtask

    // receiver stalls: short and long, with free-running stretches
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            m_ready <= 1'b1;
            if (rx_free > 0) begin
                rx_free <= rx_free - 1;
            end else begin
                case ($urandom_range(0, 99)) inside
                    [0:9]:   rx_free <= $urandom_range(50, 200);
                    [10:29]: rx_hold <= $urandom_range(1, 3);
                    [30:32]: rx_hold <= $urandom_range(8, 40);
                    default: ;
                endcase
            end
        end
    end

    // result checker against the oldest expectation
    always @(posedge aclk) begin
        lit_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result value=%h status=%0d",
                                          m_value, m_status));
            end else begin
                want = pending_results.pop_front();
                results_seen++;
                case (want.status)
                    ST_OK:       ok_seen++;
                    ST_BAD:      bad_seen++;
                    default:     ovf_seen++;
                endcase
                if (m_value !== want.value)
                    report_mismatch($sformatf("result %0d value %h, expected %h",
                                              results_seen, m_value, want.value));
                if (m_status !== want.status)
                    report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                              results_seen, m_status, want.status));
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("[%0t] timeout: no beat for %0d cycles, %0d results outstanding",
                         $time, IDLE_LIMIT, pending_results.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        char_q_t     chars;
        lit_result_t want;
        clear_literal();

        // directed literals: typed expectations where obvious
        lit_rows.push_back('{"", 1'b1, 32'h0, ST_BAD});
        lit_rows.push_back('{"0", 1'b1, 32'h0, ST_OK});
        lit_rows.push_back('{"0x", 1'b1, 32'h0, ST_OK});
        lit_rows.push_back('{"0X", 1'b1, 32'h0, ST_OK});
        lit_rows.push_back('{"4294967295", 1'b1, 32'hFFFF_FFFF, ST_OK});
        lit_rows.push_back('{"4294967296", 1'b1, 32'hFFFF_FFFF, ST_OVERFLOW});
        lit_rows.push_back('{"0xFFFFFFFF", 1'b1, 32'hFFFF_FFFF, ST_OK});
        lit_rows.push_back('{"0x100000000", 1'b1, 32'hFFFF_FFFF, ST_OVERFLOW});
        lit_rows.push_back('{"037777777777", 1'b1, 32'hFFFF_FFFF, ST_OK});
        lit_rows.push_back('{"040000000000", 1'b1, 32'hFFFF_FFFF, ST_OVERFLOW});
        lit_rows.push_back('{"0x1aF", 1'b1, 32'h1AF, ST_OK});
        lit_rows.push_back('{"0178", 1'b1, 32'd15, ST_OK});
        lit_rows.push_back('{"0189", 1'b1, 32'd1, ST_OK});
        lit_rows.push_back('{"09", 1'b1, 32'd0, ST_OK});
        lit_rows.push_back('{"00", 1'b1, 32'd0, ST_OK});
        lit_rows.push_back('{"0179a", 1'b1, 32'h0, ST_BAD});
        lit_rows.push_back('{"a12", 1'b1, 32'h0, ST_BAD});
        lit_rows.push_back('{"12x", 1'b1, 32'h0, ST_BAD});
        lit_rows.push_back('{"0xg", 1'b1, 32'h0, ST_BAD});
        lit_rows.push_back('{"0xx", 1'b1, 32'h0, ST_BAD});
        lit_rows.push_back('{"99999999999z", 1'b1, 32'h0, ST_BAD});
        lit_rows.push_back('{"\377", 1'b1, 32'h0, ST_BAD});
        lit_rows.push_back('{"0x\200", 1'b1, 32'h0, ST_BAD});
        lit_rows.push_back('{"123", 1'b0, 32'h0, ST_OK});
        lit_rows.push_back('{"0x0123456789abcdefABCDEF", 1'b0, 32'h0, ST_OK});

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (lit_rows[r]) begin
            chars.delete();
            for (int i = 0; i < lit_rows[r].text.len(); i++)
                chars.push_back(lit_rows[r].text[i]);
            want.value  = lit_rows[r].value;
            want.status = lit_rows[r].status;
            send_literal(chars, lit_rows[r].typed, want);
        end
        drain_results();

        // random strings, with one full drain midway
        while (chars_sent < CHAR_BUDGET / 2) random_literal();
        drain_results();
        while (chars_sent < CHAR_BUDGET) random_literal();

        drain_results();
        repeat (8) @(posedge aclk);

        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        $display("sent %0d strings in %0d characters, checked %0d results",
                 strings_sent, chars_sent, results_seen);
        $display("results by status: ok %0d, bad syntax %0d, overflow %0d",
                 ok_seen, bad_seen, ovf_seen);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
